// File: hdl/touch_key_press_detector_macros.svh
// Assertion macros used by the touch key press detector RTL.
`ifndef TOUCH_KEY_PRESS_DETECTOR_MACROS_SVH
`define TOUCH_KEY_PRESS_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TKPD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkpd assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TKPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tkpd assertion failed");

`endif

// File: hdl/tkpd_pkg.sv
// Types, codes and constants of the touch key press detector.
package tkpd_pkg;

   localparam int NUM_CHANNELS_DEF = 16;
   localparam int CHAN_W = 4;
   localparam int VALUE_W = 16;
   localparam int RATIO_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [RATIO_W-1:0] PRESS_RATIO_RESET = 8'd26;
   localparam logic [RATIO_W-1:0] RELEASE_RATIO_RESET = 8'd13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_ENABLE = 2'd0,
      CSR_LOWPASS_ENABLE = 2'd1,
      CSR_PRESS_RATIO    = 2'd2,
      CSR_RELEASE_RATIO  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_LOAD   = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [VALUE_W-1:0] channel_enable;
      logic               lowpass_enable;
      logic [RATIO_W-1:0] press_ratio_q8;
      logic [RATIO_W-1:0] release_ratio_q8;
   } cfg_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [CHAN_W-1:0]  channel;
      logic [VALUE_W-1:0] sample_value;
   } item_type;

endpackage

// File: hdl/tkpd_csr.sv
// Configuration register file of the touch key press detector.
module tkpd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tkpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tkpd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output tkpd_pkg::cfg_type                    cfg
);

   tkpd_pkg::cfg_type cfg_ff;
   tkpd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tkpd_pkg::CSR_CHANNEL_ENABLE: begin
               cfg_in.channel_enable = csr_wdata;
            end
            tkpd_pkg::CSR_LOWPASS_ENABLE: begin
               cfg_in.lowpass_enable = csr_wdata[0];
            end
            tkpd_pkg::CSR_PRESS_RATIO: begin
               cfg_in.press_ratio_q8 = csr_wdata[tkpd_pkg::RATIO_W-1:0];
            end
            tkpd_pkg::CSR_RELEASE_RATIO: begin
               cfg_in.release_ratio_q8 = csr_wdata[tkpd_pkg::RATIO_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_enable   <= '0;
         cfg_ff.lowpass_enable   <= 1'b0;
         cfg_ff.press_ratio_q8   <= tkpd_pkg::PRESS_RATIO_RESET;
         cfg_ff.release_ratio_q8 <= tkpd_pkg::RELEASE_RATIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/tkpd_eval.sv
// Channel stores, threshold evaluation and result register.
`include "touch_key_press_detector_macros.svh"

module tkpd_eval #(
   parameter int NUM_CHANNELS = tkpd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tkpd_pkg::cfg_type                 cfg,
   input  logic                              item_valid,
   input  tkpd_pkg::item_type                item,
   output logic                              take,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tkpd_pkg::VALUE_W-1:0]      rsp_pressed_keys,
   output logic                              rsp_any_pressed,
   output logic [tkpd_pkg::VALUE_W-1:0]      rsp_channel_value,
   output logic                              rsp_round_done
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int VW = tkpd_pkg::VALUE_W;
   localparam int PW = tkpd_pkg::VALUE_W + tkpd_pkg::RATIO_W;

   logic [VW-1:0]           filt_ff [NUM_CHANNELS];
   logic [VW-1:0]           base_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] key_status_ff;
   logic [NUM_CHANNELS-1:0] key_status_in;

   logic                    rsp_vld_ff;
   logic [VW-1:0]           pressed_ff;
   logic                    any_ff;
   logic [VW-1:0]           chv_ff;
   logic                    done_ff;

   logic                    in_range;
   logic                    is_sample;
   logic [IDX_W-1:0]        idx;
   logic [VW-1:0]           old_val;
   logic [VW-1:0]           base_val;
   logic [VW+1:0]           old_x3;
   logic [VW-1:0]           lp_val;
   logic [VW-1:0]           filt_in;
   logic                    neg_drop;
   logic [PW-1:0]           drop;
   logic [PW-1:0]           press_th;
   logic [PW-1:0]           release_th;
   logic                    press_hit;
   logic                    release_hit;
   logic [NUM_CHANNELS-1:0] en;
   logic [NUM_CHANNELS-1:0] ch_bit;
   logic [tkpd_pkg::CHAN_W-1:0] top_ch;
   logic [VW-1:0]           pressed_in;
   logic [VW-1:0]           chv_in;
   logic                    done_in;

   assign take = item_valid && (!rsp_vld_ff || !rsp_stall);

   assign in_range  = {1'b0, item.channel} < (tkpd_pkg::CHAN_W + 1)'(NUM_CHANNELS);
   assign is_sample = (item.opcode == tkpd_pkg::OP_SAMPLE);
   assign idx       = item.channel[IDX_W-1:0];
   assign old_val   = filt_ff[idx];
   assign base_val  = base_ff[idx];

   // old*3/4 + raw/16, never exceeds 16 bits
   assign old_x3  = {1'b0, old_val, 1'b0} + {2'b00, old_val};
   assign lp_val  = VW'(old_x3[VW+1:2]) + VW'(item.sample_value[VW-1:4]);
   assign filt_in = cfg.lowpass_enable ? lp_val : item.sample_value;

   assign neg_drop    = filt_in > base_val;
   assign drop        = {base_val - filt_in, 8'h00};
   assign press_th    = PW'(cfg.press_ratio_q8) * PW'(base_val);
   assign release_th  = PW'(cfg.release_ratio_q8) * PW'(base_val);
   assign press_hit   = !neg_drop && (drop >= press_th);
   assign release_hit = neg_drop || (drop <= release_th);

   assign en     = cfg.channel_enable[NUM_CHANNELS-1:0];
   assign ch_bit = NUM_CHANNELS'(1) << idx;

   always_comb begin
      top_ch = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (en[i]) begin
            top_ch = tkpd_pkg::CHAN_W'(i);
         end
      end
   end

   always_comb begin
      key_status_in = key_status_ff;
      if (in_range && is_sample) begin
         if (press_hit) begin
            key_status_in = key_status_ff | ch_bit;
         end else if (release_hit) begin
            key_status_in = key_status_ff & ~ch_bit;
         end
      end
   end

   assign pressed_in = VW'(key_status_in & en);
   assign chv_in     = !in_range ? '0 : (is_sample ? filt_in : old_val);
   assign done_in    = in_range && is_sample && (en != '0) && (item.channel == top_ch);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_status_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            filt_ff[i] <= '0;
            base_ff[i] <= '1;
         end
      end else if (take) begin
         key_status_ff <= key_status_in;
         if (in_range) begin
            if (is_sample) begin
               filt_ff[idx] <= filt_in;
            end else begin
               base_ff[idx] <= item.sample_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (take) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pressed_ff <= pressed_in;
         any_ff     <= (pressed_in != '0);
         chv_ff     <= chv_in;
         done_ff    <= done_in;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_pressed_keys  = pressed_ff;
   assign rsp_any_pressed   = any_ff;
   assign rsp_channel_value = chv_ff;
   assign rsp_round_done    = done_ff;

   `TKPD_ASSERT_NEXT(a_load_keeps_status, clock, reset, take && !is_sample, $stable(key_status_ff))
   `TKPD_ASSERT_NEXT(a_neg_drop_clears, clock, reset, take && is_sample && in_range && neg_drop, !key_status_ff[$past(idx)])
   `TKPD_ASSERT_NEXT(a_press_sets, clock, reset, take && is_sample && in_range && press_hit, key_status_ff[$past(idx)])
   `TKPD_ASSERT_IMPL(a_done_in_range, clock, reset, take && done_in, in_range && is_sample && en[idx])

endmodule

// File: hdl/touch_key_press_detector.sv
// Touch key press detector top level: input register, evaluation and configuration.
// A transaction is held in the input register, then its result is written to the result register.
// Throughput: one transaction per cycle while rsp_stall is low, set by the single pass from input to result register.
// Reset: synchronous, active high; value stores clear to zero, baselines to all ones.
// Configuration registers return to their listed defaults on reset.
module touch_key_press_detector #(
   parameter int NUM_CHANNELS = tkpd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [tkpd_pkg::CHAN_W-1:0]       req_channel,
   input  logic [tkpd_pkg::VALUE_W-1:0]      req_sample_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tkpd_pkg::VALUE_W-1:0]      rsp_pressed_keys,
   output logic                              rsp_any_pressed,
   output logic [tkpd_pkg::VALUE_W-1:0]      rsp_channel_value,
   output logic                              rsp_round_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tkpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tkpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tkpd_pkg::cfg_type  cfg;
   tkpd_pkg::item_type item_ff;
   logic               in_vld_ff;
   logic               take;
   logic               accept;

   assign req_stall = in_vld_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (accept) begin
         in_vld_ff <= 1'b1;
      end else if (take) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode       <= tkpd_pkg::opcode_type'(req_opcode);
         item_ff.channel      <= req_channel;
         item_ff.sample_value <= req_sample_value;
      end
   end

   tkpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tkpd_eval #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_eval (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .item_valid        (in_vld_ff),
      .item              (item_ff),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pressed_keys  (rsp_pressed_keys),
      .rsp_any_pressed   (rsp_any_pressed),
      .rsp_channel_value (rsp_channel_value),
      .rsp_round_done    (rsp_round_done)
   );

endmodule
